// File: design/htlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htlp_pkg
// Shared types and constants of the linear-probing hash table.
// ----------------------------------------------------------------------------
package htlp_pkg;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned LenW    = 4;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned HashW   = 32;

  localparam logic [HashW-1:0] FnvBasis = 32'h811C_9DC5;
  localparam logic [HashW-1:0] FnvPrime = 32'h0100_0193;

  localparam logic CmdGet = 1'b0;
  localparam logic CmdSet = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StatusHit      = 3'd0,
    StatusMiss     = 3'd1,
    StatusInserted = 3'd2,
    StatusUpdated  = 3'd3,
    StatusFull     = 3'd4
  } status_e;

endpackage
`default_nettype wire

// File: design/htlp_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htlp_hash
// FNV-1a over the key bytes, one byte per cycle, followed by a reduction of
// the hash modulo the table depth by reciprocal multiplication.
// ----------------------------------------------------------------------------
module htlp_hash #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [htlp_pkg::KeyW-1:0]          key_i,
  input  wire logic [htlp_pkg::LenW-1:0]          len_i,
  output logic                                    done_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]          slot_o
);

  localparam int unsigned IdxW   = $clog2(TABLE_DEPTH);
  localparam int unsigned RecipS = htlp_pkg::HashW + IdxW;
  localparam int unsigned RecipW = htlp_pkg::HashW + 1;
  localparam int unsigned ProdW  = htlp_pkg::HashW + RecipW;
  localparam logic [RecipW-1:0] RecipM =
    RecipW'(((64'd1 << RecipS) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));
  localparam logic [htlp_pkg::HashW-1:0] DepthH = htlp_pkg::HashW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    HashIdle,
    HashBytes,
    HashQuot,
    HashRem
  } hash_state_e;

  hash_state_e                  state_q;
  logic [htlp_pkg::HashW-1:0]   h_q;
  logic [htlp_pkg::HashW-1:0]   h_mul;
  logic [htlp_pkg::KeyW-1:0]    key_q;
  logic [htlp_pkg::LenW-1:0]    len_q;
  logic [htlp_pkg::LenW-1:0]    cnt_q;
  logic [ProdW-1:0]             prod;
  logic [htlp_pkg::HashW-1:0]   quot_q;
  logic [htlp_pkg::HashW-1:0]   rem;
  logic                         done_q;
  logic [IdxW-1:0]              slot_q;

  assign h_mul = (h_q ^ {24'h00_0000, key_q[7:0]}) * htlp_pkg::FnvPrime;
  assign prod  = ProdW'(h_q) * ProdW'(RecipM);
  assign rem   = h_q - quot_q * DepthH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HashIdle;
      h_q     <= '0;
      key_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      quot_q  <= '0;
      done_q  <= 1'b0;
      slot_q  <= '0;
    end else begin
      done_q <= (state_q == HashRem);
      case (state_q)
        HashIdle: begin
          if (start_i) begin
            h_q     <= htlp_pkg::FnvBasis;
            key_q   <= key_i;
            len_q   <= len_i;
            cnt_q   <= '0;
            state_q <= HashBytes;
          end
        end
        HashBytes: begin
          if (cnt_q == len_q) begin
            state_q <= HashQuot;
          end else begin
            h_q   <= h_mul;
            key_q <= key_q >> 8;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        HashQuot: begin
          quot_q  <= htlp_pkg::HashW'(prod[ProdW-1:RecipS]);
          state_q <= HashRem;
        end
        HashRem: begin
          slot_q  <= rem[IdxW-1:0];
          state_q <= HashIdle;
        end
        default: begin
          state_q <= HashIdle;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign slot_o = slot_q;

endmodule
`default_nettype wire

// File: design/htlp_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htlp_mem
// Slot store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module htlp_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 101
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: design/hash_table_linear_probe_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hash_table_linear_probe_top
// Key-value table with FNV-1a hashing and linear probing. After reset the
// block sweeps the slot memory once to clear every valid flag, during
// which no input transaction is accepted. An operation is handled one at
// a time: the first key_length bytes are hashed, where key_length is
// saturated to KEY_BYTES, the hash is reduced modulo the table depth, and
// the probe reads one slot per cycle from the slot memory until it meets
// the key, an empty slot or the last slot of a full sweep. Once three
// quarters of the slots hold keys, sets of new keys are refused with the
// full status; updates and gets still succeed. The next input transaction
// is taken while a result still waits at the output.
// ----------------------------------------------------------------------------
module hash_table_linear_probe_top #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_BYTES   = 8,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                cmd_i,
  input  wire logic [htlp_pkg::KeyW-1:0]           key_bytes_i,
  input  wire logic [htlp_pkg::LenW-1:0]           key_length_i,
  input  wire logic [htlp_pkg::ValW-1:0]           value_in_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [htlp_pkg::StatusW-1:0]             status_o,
  output logic [htlp_pkg::ValW-1:0]                value_out_o
);

  localparam int unsigned IdxW      = $clog2(TABLE_DEPTH);
  localparam int unsigned StoreBits = (VALUE_BITS < htlp_pkg::ValW) ? VALUE_BITS
                                                                    : htlp_pkg::ValW;
  localparam int unsigned WordW     = 1 + htlp_pkg::LenW + htlp_pkg::KeyW + StoreBits;
  localparam int unsigned CntW      = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned FullLimit = (TABLE_DEPTH * 3) / 4;

  typedef enum logic [1:0] {
    StateClear,
    StateIdle,
    StateHash,
    StateProbe
  } state_e;

  state_e                         state_q;
  logic [IdxW-1:0]                clr_q;
  logic [IdxW-1:0]                addr_q;
  logic [IdxW-1:0]                addr_next;
  logic [IdxW-1:0]                probe_q;
  logic [CntW-1:0]                entry_count_q;
  logic                           cmd_q;
  logic [htlp_pkg::KeyW-1:0]      key_q;
  logic [htlp_pkg::LenW-1:0]      len_q;
  logic [StoreBits-1:0]           val_q;
  logic                           out_valid_q;
  htlp_pkg::status_e              status_q;
  htlp_pkg::status_e              status_d;
  logic [htlp_pkg::ValW-1:0]      value_out_q;
  logic [htlp_pkg::ValW-1:0]      value_out_d;

  logic [htlp_pkg::LenW-1:0]      len_sat;
  logic [htlp_pkg::KeyW-1:0]      key_masked;
  logic                           accept;
  logic                           hash_done;
  logic [IdxW-1:0]                hash_slot;

  logic                           mem_we;
  logic [IdxW-1:0]                mem_waddr;
  logic [WordW-1:0]               mem_wdata;
  logic                           mem_re;
  logic [IdxW-1:0]                mem_raddr;
  logic [WordW-1:0]               mem_rdata;

  logic                           rd_valid;
  logic [htlp_pkg::LenW-1:0]      rd_len;
  logic [htlp_pkg::KeyW-1:0]      rd_key;
  logic [StoreBits-1:0]           rd_val;
  logic                           hit;
  logic                           empty;
  logic                           terminal;
  logic                           out_free;
  logic                           commit;
  logic                           do_insert;
  logic                           do_update;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    if (key_length_i > htlp_pkg::LenW'(KEY_BYTES)) begin
      len_sat = htlp_pkg::LenW'(KEY_BYTES);
    end else begin
      len_sat = key_length_i;
    end
    for (int b = 0; b < htlp_pkg::KeyW / 8; b++) begin
      if (htlp_pkg::LenW'(b) < len_sat) begin
        key_masked[8*b +: 8] = key_bytes_i[8*b +: 8];
      end else begin
        key_masked[8*b +: 8] = 8'h00;
      end
    end
  end

  htlp_hash #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .key_i  (key_masked),
    .len_i  (len_sat),
    .done_o (hash_done),
    .slot_o (hash_slot)
  );

  htlp_mem #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(WordW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign rd_valid = mem_rdata[WordW-1];
  assign rd_len   = mem_rdata[WordW-2 -: htlp_pkg::LenW];
  assign rd_key   = mem_rdata[StoreBits +: htlp_pkg::KeyW];
  assign rd_val   = mem_rdata[StoreBits-1:0];

  assign addr_next = (addr_q == IdxW'(TABLE_DEPTH - 1)) ? '0 : addr_q + 1'b1;

  always_comb begin
    hit       = rd_valid && (rd_len == len_q) && (rd_key == key_q);
    empty     = !rd_valid;
    terminal  = hit || empty || (probe_q == IdxW'(TABLE_DEPTH - 1));
    out_free  = !out_valid_q || out_ready_i;
    commit    = (state_q == StateProbe) && terminal && out_free;
    do_update = commit && (cmd_q == htlp_pkg::CmdSet) && hit;
    do_insert = commit && (cmd_q == htlp_pkg::CmdSet) && !hit && empty &&
                (entry_count_q < CntW'(FullLimit));

    value_out_d = '0;
    if (cmd_q == htlp_pkg::CmdGet) begin
      if (hit) begin
        status_d    = htlp_pkg::StatusHit;
        value_out_d = htlp_pkg::ValW'(rd_val);
      end else begin
        status_d = htlp_pkg::StatusMiss;
      end
    end else if (hit) begin
      status_d = htlp_pkg::StatusUpdated;
    end else if (empty && (entry_count_q < CntW'(FullLimit))) begin
      status_d = htlp_pkg::StatusInserted;
    end else begin
      status_d = htlp_pkg::StatusFull;
    end

    if (state_q == StateClear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = do_update || do_insert;
      mem_waddr = addr_q;
      mem_wdata = {1'b1, len_q, key_q, val_q};
    end

    mem_re    = hash_done || ((state_q == StateProbe) && !terminal);
    mem_raddr = hash_done ? hash_slot : addr_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StateClear;
      clr_q         <= '0;
      addr_q        <= '0;
      probe_q       <= '0;
      entry_count_q <= '0;
      cmd_q         <= htlp_pkg::CmdGet;
      key_q         <= '0;
      len_q         <= '0;
      val_q         <= '0;
      out_valid_q   <= 1'b0;
      status_q      <= htlp_pkg::StatusMiss;
      value_out_q   <= '0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StateClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IdxW'(TABLE_DEPTH - 1)) begin
            state_q <= StateIdle;
          end
        end
        StateIdle: begin
          if (accept) begin
            cmd_q   <= cmd_i;
            key_q   <= key_masked;
            len_q   <= len_sat;
            val_q   <= value_in_i[StoreBits-1:0];
            state_q <= StateHash;
          end
        end
        StateHash: begin
          if (hash_done) begin
            addr_q  <= hash_slot;
            probe_q <= '0;
            state_q <= StateProbe;
          end
        end
        StateProbe: begin
          if (commit) begin
            status_q    <= status_d;
            value_out_q <= value_out_d;
            if (do_insert) begin
              entry_count_q <= entry_count_q + 1'b1;
            end
            state_q <= StateIdle;
          end else if (!terminal) begin
            addr_q  <= addr_next;
            probe_q <= probe_q + 1'b1;
          end
        end
        default: begin
          state_q <= StateIdle;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == StateIdle);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_out_o = value_out_q;

`ifndef ASSERT_OFF
  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && status_d == htlp_pkg::StatusInserted) |=>
      (entry_count_q == $past(entry_count_q) + 1'b1))
    else $error("Insert did not advance the entry count.");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= CntW'(FullLimit))
    else $error("Entry count exceeds the occupancy limit.");

  a_value_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != htlp_pkg::StatusHit) |-> (value_out_o == '0))
    else $error("Nonzero value on a transaction without a get hit.");

  a_hash_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> (state_q == StateHash))
    else $error("Hash result arrived outside the hash wait state.");
`endif

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linear-probing hash table. A shadow table
// hashes each accepted key with FNV-1a, probes it the same way and keeps its
// own slots, so every get and set transaction yields the status and value
// that must come back. Directed keys cover empty, overlong and padded keys;
// a random phase draws mostly from a fixed key pool until the table fills
// and sets of new keys are refused. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned KeyBytes   = 8;
  localparam int unsigned FullLimit  = (TableDepth * 3) / 4;
  localparam int unsigned PoolSize   = 320;
  localparam int unsigned RandomOps  = 1600;
  localparam int unsigned DrainWait  = 400;
  localparam int unsigned CycleLimit = 4000000;
  localparam time         ClkPeriod  = 8ns;

  typedef struct packed {
    logic                      cmd;
    logic [htlp_pkg::KeyW-1:0] key;
    logic [htlp_pkg::LenW-1:0] len;
    logic [htlp_pkg::ValW-1:0] val;
  } table_op_t;

  typedef struct packed {
    htlp_pkg::status_e         status;
    logic [htlp_pkg::ValW-1:0] value;
  } table_reply_t;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_ready_o;
  logic                         cmd_i        = htlp_pkg::CmdGet;
  logic [htlp_pkg::KeyW-1:0]    key_bytes_i  = '0;
  logic [htlp_pkg::LenW-1:0]    key_length_i = '0;
  logic [htlp_pkg::ValW-1:0]    value_in_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i  = 1'b0;
  logic [htlp_pkg::StatusW-1:0] status_o;
  logic [htlp_pkg::ValW-1:0]    value_out_o;

  table_op_t    op_queue[$];
  table_reply_t replies_due[$];

  bit                        tbl_valid [TableDepth];
  logic [htlp_pkg::KeyW-1:0] tbl_key   [TableDepth];
  logic [htlp_pkg::LenW-1:0] tbl_len   [TableDepth];
  logic [htlp_pkg::ValW-1:0] tbl_value [TableDepth];
  int unsigned               tbl_count = 0;

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap    = 0;
  int unsigned send_calm   = 0;
  int unsigned recv_stall  = 0;
  int unsigned recv_calm   = 0;

  hash_table_linear_probe_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .key_bytes_i (key_bytes_i),
    .key_length_i(key_length_i),
    .value_in_i  (value_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .value_out_o (value_out_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic logic [htlp_pkg::KeyW-1:0] len_mask(int unsigned len);
    if (len >= KeyBytes) begin
      return '1;
    end
    return (64'd1 << (8 * len)) - 64'd1;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic lookup_or_store(input logic cmd,
                                 input logic [htlp_pkg::KeyW-1:0] key_raw,
                                 input logic [htlp_pkg::LenW-1:0] len_raw,
                                 input logic [htlp_pkg::ValW-1:0] val);
    int unsigned                len;
    logic [htlp_pkg::KeyW-1:0]  key;
    logic [htlp_pkg::HashW-1:0] h;
    int unsigned                idx;
    bit                         hit;
    bit                         empty;
    table_reply_t               reply;
    len = (len_raw > KeyBytes) ? KeyBytes : len_raw;
    key = key_raw & len_mask(len);
    h = htlp_pkg::FnvBasis;
    for (int i = 0; i < len; i++) begin
      h = h ^ {24'd0, key[8*i +: 8]};
      h = h * htlp_pkg::FnvPrime;
    end
    idx = h % TableDepth;
    hit = 1'b0;
    empty = 1'b0;
    for (int n = 0; n < TableDepth; n++) begin
      if (!tbl_valid[idx]) begin
        empty = 1'b1;
        break;
      end
      if (tbl_len[idx] == len && tbl_key[idx] == key) begin
        hit = 1'b1;
        break;
      end
      idx = (idx + 1) % TableDepth;
    end
    reply.value = '0;
    if (cmd == htlp_pkg::CmdGet) begin
      if (hit) begin
        reply.status = htlp_pkg::StatusHit;
        reply.value = tbl_value[idx];
      end else begin
        reply.status = htlp_pkg::StatusMiss;
      end
    end else if (hit) begin
      tbl_value[idx] = val;
      reply.status = htlp_pkg::StatusUpdated;
    end else if (tbl_count >= FullLimit || !empty) begin
      reply.status = htlp_pkg::StatusFull;
    end else begin
      tbl_valid[idx] = 1'b1;
      tbl_key[idx] = key;
      tbl_len[idx] = len;
      tbl_value[idx] = val;
      tbl_count++;
      reply.status = htlp_pkg::StatusInserted;
    end
    replies_due.push_back(reply);
  endtask

  task automatic queue_op(input logic cmd, input logic [htlp_pkg::KeyW-1:0] key,
                          input logic [htlp_pkg::LenW-1:0] len,
                          input logic [htlp_pkg::ValW-1:0] val);
    table_op_t op;
    op.cmd = cmd;
    op.key = key;
    op.len = len;
    op.val = val;
    op_queue.push_back(op);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_op_t op;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
      send_calm <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        lookup_or_store(cmd_i, key_bytes_i, key_length_i, value_in_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (op_queue.size() != 0) begin
          op = op_queue.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= op.cmd;
          key_bytes_i <= op.key;
          key_length_i <= op.len;
          value_in_i <= op.val;
          if (send_calm != 0) begin
            send_calm <= send_calm - 1;
            send_gap <= 0;
          end else if ($urandom_range(0, 39) == 0) begin
            send_calm <= $urandom_range(20, 60);
            send_gap <= 0;
          end else begin
            send_gap <= idle_len();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    table_reply_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall <= 0;
      recv_calm <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result: status %0d, value_out 0x%08h", status_o, value_out_o);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (value_out_o !== want.value) begin
            $error("value_out: expected 0x%08h, got 0x%08h", want.value, value_out_o);
            mismatches++;
          end
        end
      end
      if (recv_calm != 0) begin
        recv_calm <= recv_calm - 1;
      end else if ($urandom_range(0, 299) == 0) begin
        recv_calm <= $urandom_range(100, 400);
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        out_ready_i <= 1'b0;
      end else if (recv_calm == 0 && $urandom_range(0, 5) == 0) begin
        recv_stall <= idle_len();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [htlp_pkg::KeyW-1:0] pool_key[PoolSize];
    logic [htlp_pkg::LenW-1:0] pool_len[PoolSize];
    logic [htlp_pkg::KeyW-1:0] key;
    logic [htlp_pkg::KeyW-1:0] mask;
    logic [htlp_pkg::LenW-1:0] len;
    logic                      cmd;
    int unsigned               p;

    queue_op(htlp_pkg::CmdGet, 64'd0, 4'd0, 32'd0);
    queue_op(htlp_pkg::CmdSet, '1, 4'd0, 32'd0);
    queue_op(htlp_pkg::CmdGet, 64'h0123_4567_89AB_CDEF, 4'd0, 32'hFFFF_FFFF);
    queue_op(htlp_pkg::CmdSet, 64'd0, 4'd0, 32'hFFFF_FFFF);
    queue_op(htlp_pkg::CmdGet, 64'd0, 4'd0, 32'd0);
    queue_op(htlp_pkg::CmdSet, '1, 4'd8, 32'h1234_5678);
    queue_op(htlp_pkg::CmdGet, '1, 4'd15, 32'd0);
    queue_op(htlp_pkg::CmdGet, '1, 4'd9, 32'd0);
    queue_op(htlp_pkg::CmdSet, 64'd0, 4'd8, 32'hA5A5_A5A5);
    queue_op(htlp_pkg::CmdGet, 64'd0, 4'd12, 32'd0);
    queue_op(htlp_pkg::CmdSet, 64'h0000_0000_0000_00AB, 4'd1, 32'h0000_0001);
    queue_op(htlp_pkg::CmdGet, 64'hFFFF_FFFF_FFFF_FFAB, 4'd1, 32'd0);
    queue_op(htlp_pkg::CmdGet, 64'h0000_0000_0000_00AB, 4'd2, 32'd0);
    queue_op(htlp_pkg::CmdSet, 64'hFFFF_FFFF_FFFF_00AB, 4'd2, 32'h8000_0000);
    queue_op(htlp_pkg::CmdGet, 64'h0000_0000_0000_00AB, 4'd2, 32'd0);
    queue_op(htlp_pkg::CmdSet, 64'h5555_5555_DEAD_BEEF, 4'd4, 32'hCAFE_F00D);
    queue_op(htlp_pkg::CmdGet, 64'hAAAA_AAAA_DEAD_BEEF, 4'd4, 32'd0);
    queue_op(htlp_pkg::CmdSet, '1, 4'd8, 32'd0);
    queue_op(htlp_pkg::CmdGet, '1, 4'd8, 32'd0);
    queue_op(htlp_pkg::CmdGet, 64'h0000_0000_0000_0001, 4'd1, 32'd0);

    for (int i = 0; i < PoolSize; i++) begin
      pool_len[i] = $urandom_range(0, KeyBytes);
      pool_key[i] = {$urandom, $urandom};
    end
    for (int n = 0; n < RandomOps; n++) begin
      cmd = ($urandom_range(0, 99) < 55) ? htlp_pkg::CmdSet : htlp_pkg::CmdGet;
      if ($urandom_range(0, 99) < 85) begin
        p = $urandom_range(0, PoolSize - 1);
        len = pool_len[p];
        mask = len_mask(len);
        key = (pool_key[p] & mask) | ({$urandom, $urandom} & ~mask);
        if (len == KeyBytes && $urandom_range(0, 3) == 0) begin
          len = $urandom_range(KeyBytes + 1, 15);
        end
      end else begin
        key = {$urandom, $urandom};
        len = $urandom_range(0, 15);
      end
      queue_op(cmd, key, len, $urandom);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_queue.size() != 0 || in_valid_i || replies_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: hash_table_linear_probe_top.f
design/htlp_pkg.sv
design/htlp_hash.sv
design/htlp_mem.sv
design/hash_table_linear_probe_top.sv
bench/testbench.sv
